// ----- rtl/cafb_pkg.sv -----
// ----------------------------------------------------------------------------
// cafb_pkg
// Shared types and codes for the CPU ALU, flags and branch unit.
// ----------------------------------------------------------------------------
package cafb_pkg;

  localparam int LEVELS  = 16;
  localparam int ROW_W   = 7;
  localparam int RF_ROWS = 1 << ROW_W;

  // item kinds
  localparam logic [2:0] CMD_ALU1   = 3'd0;
  localparam logic [2:0] CMD_ALU2   = 3'd1;
  localparam logic [2:0] CMD_SYS    = 3'd2;
  localparam logic [2:0] CMD_BRANCH = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // single-register ops
  localparam logic [3:0] OP1_INC = 4'd0;
  localparam logic [3:0] OP1_DEC = 4'd1;
  localparam logic [3:0] OP1_CLR = 4'd2;
  localparam logic [3:0] OP1_NOT = 4'd3;
  localparam logic [3:0] OP1_SHL = 4'd4;
  localparam logic [3:0] OP1_SHR = 4'd5;
  localparam logic [3:0] OP1_ROL = 4'd6;
  localparam logic [3:0] OP1_ROR = 4'd7;

  // two-register ops
  localparam logic [3:0] OP2_ADD = 4'd0;
  localparam logic [3:0] OP2_SUB = 4'd1;
  localparam logic [3:0] OP2_AND = 4'd2;
  localparam logic [3:0] OP2_OR  = 4'd3;
  localparam logic [3:0] OP2_XOR = 4'd4;
  localparam logic [3:0] OP2_MOV = 4'd5;

  // system ops
  localparam logic [3:0] SYS_STOP  = 4'd0;
  localparam logic [3:0] SYS_SET_M = 4'd2;
  localparam logic [3:0] SYS_CLR_M = 4'd3;
  localparam logic [3:0] SYS_SET_I = 4'd4;
  localparam logic [3:0] SYS_CLR_I = 4'd5;
  localparam logic [3:0] SYS_SET_C = 4'd6;
  localparam logic [3:0] SYS_CLR_C = 4'd7;
  localparam logic [3:0] SYS_RET   = 4'd9;

  // branch conditions
  localparam logic [3:0] BR_C      = 4'd0;
  localparam logic [3:0] BR_M      = 4'd2;
  localparam logic [3:0] BR_Z      = 4'd4;
  localparam logic [3:0] BR_LT     = 4'd6;
  localparam logic [3:0] BR_GT     = 4'd8;
  localparam logic [3:0] BR_SENSE0 = 4'd10;
  localparam logic [3:0] BR_NEVER  = 4'd14;

  // register holding the return address
  localparam logic [3:0] RET_REG = 4'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        word_size;
    logic [3:0]  op;
    logic [7:0]  addr_a;
    logic [7:0]  addr_b;
    logic [3:0]  cnt;
    logic [7:0]  offset;
    logic [15:0] pc;
    logic [3:0]  sense;
    logic [7:0]  wbyte;
  } item_t;

  typedef struct packed {
    logic c;
    logic v;
    logic z;
    logic m;
    logic i;
  } flags_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic             we_hi;
    logic             we_lo;
    logic [7:0]       hi;
    logic [7:0]       lo;
  } wr_req_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
    logic        pc_load;
    logic [15:0] new_pc;
    logic        halted;
  } res_t;

endpackage

// ----- rtl/cafb_regfile.sv -----
// ----------------------------------------------------------------------------
// cafb_regfile
// Banked register file as two byte-wide memories (even and odd bytes), two
// registered read ports, one write port, per-byte valid bits and bypass of
// the write that lands on the read edge.
// ----------------------------------------------------------------------------
module cafb_regfile
  import cafb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_row_a,
  input  logic [ROW_W-1:0] rd_row_b,
  input  wr_req_t          wr,
  output logic [15:0]      rd_data_a,
  output logic [15:0]      rd_data_b
);

  logic [7:0]         mem_hi_r [RF_ROWS];
  logic [7:0]         mem_lo_r [RF_ROWS];
  logic [RF_ROWS-1:0] vld_hi_r;
  logic [RF_ROWS-1:0] vld_lo_r;

  logic [7:0]       q_hi_a_r, q_lo_a_r, q_hi_b_r, q_lo_b_r;
  logic             qv_hi_a_r, qv_lo_a_r, qv_hi_b_r, qv_lo_b_r;
  logic [ROW_W-1:0] row_a_r, row_b_r;
  wr_req_t          fwd_r;

  logic hit_a, hit_b;

  always_ff @(posedge clk) begin
    if (wr.en && wr.we_hi) begin
      mem_hi_r[wr.row] <= wr.hi;
    end
    if (rd_en) begin
      q_hi_a_r <= mem_hi_r[rd_row_a];
      q_hi_b_r <= mem_hi_r[rd_row_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.we_lo) begin
      mem_lo_r[wr.row] <= wr.lo;
    end
    if (rd_en) begin
      q_lo_a_r <= mem_lo_r[rd_row_a];
      q_lo_b_r <= mem_lo_r[rd_row_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_hi_r <= '0;
      vld_lo_r <= '0;
    end else if (wr.en) begin
      if (wr.we_hi) vld_hi_r[wr.row] <= 1'b1;
      if (wr.we_lo) vld_lo_r[wr.row] <= 1'b1;
    end
  end

  // capture read qualifiers and the write of the same edge for bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      qv_hi_a_r <= vld_hi_r[rd_row_a];
      qv_lo_a_r <= vld_lo_r[rd_row_a];
      qv_hi_b_r <= vld_hi_r[rd_row_b];
      qv_lo_b_r <= vld_lo_r[rd_row_b];
      row_a_r   <= rd_row_a;
      row_b_r   <= rd_row_b;
      fwd_r     <= wr;
    end
  end

  assign hit_a = fwd_r.en && (fwd_r.row == row_a_r);
  assign hit_b = fwd_r.en && (fwd_r.row == row_b_r);

  always_comb begin
    rd_data_a[15:8] = (hit_a && fwd_r.we_hi) ? fwd_r.hi : (qv_hi_a_r ? q_hi_a_r : 8'h00);
    rd_data_a[7:0]  = (hit_a && fwd_r.we_lo) ? fwd_r.lo : (qv_lo_a_r ? q_lo_a_r : 8'h00);
    rd_data_b[15:8] = (hit_b && fwd_r.we_hi) ? fwd_r.hi : (qv_hi_b_r ? q_hi_b_r : 8'h00);
    rd_data_b[7:0]  = (hit_b && fwd_r.we_lo) ? fwd_r.lo : (qv_lo_b_r ? q_lo_b_r : 8'h00);
  end

endmodule

// ----- rtl/cafb_alu.sv -----
// ----------------------------------------------------------------------------
// cafb_alu
// Execute stage: ALU ops, flag ops, branch test, raw register access and the
// write-back request for the register file.
// ----------------------------------------------------------------------------
module cafb_alu
  import cafb_pkg::*;
(
  input  item_t       it,
  input  flags_t      flags,
  input  logic        halted,
  input  logic [15:0] rd_a,
  input  logic [15:0] rd_b,
  output res_t        res_o,
  output wr_req_t     wr_o
);

  logic [4:0]  n;
  logic [15:0] mask, top;
  logic [7:0]  a_byte, b_byte;
  logic [15:0] arg, src, res;
  logic [16:0] inc_sum, add_sum;
  logic [15:0] dec_diff, sub_diff;
  logic [31:0] shl_ext;
  logic [16:0] shr_ext;
  logic [15:0] rol_b, ror_b;
  logic [31:0] rol_w, ror_w;
  logic [15:0] rol_res, ror_res;
  logic [3:0]  cond_op;
  logic [1:0]  sidx;
  logic        cond, setzm, wr_word;
  logic [7:0]  wr_byte;
  flags_t      f;

  always_comb begin
    n        = {1'b0, it.cnt} + 5'd1;
    mask     = it.word_size ? 16'hFFFF : 16'h00FF;
    top      = it.word_size ? 16'h8000 : 16'h0080;
    a_byte   = it.addr_a[0] ? rd_a[7:0] : rd_a[15:8];
    b_byte   = it.addr_b[0] ? rd_b[7:0] : rd_b[15:8];
    arg      = it.word_size ? rd_a : {8'h00, a_byte};
    src      = it.word_size ? rd_b : {8'h00, b_byte};
    inc_sum  = {1'b0, arg} + {12'h000, n};
    dec_diff = arg - {11'h000, n};
    add_sum  = {1'b0, arg} + {1'b0, src};
    sub_diff = arg - src;
    shl_ext  = {16'h0000, arg} << n;
    shr_ext  = {arg, 1'b0} >> n;
    rol_b    = {arg[7:0], arg[7:0]} << n[2:0];
    ror_b    = {arg[7:0], arg[7:0]} >> n[2:0];
    rol_w    = {arg, arg} << n[3:0];
    ror_w    = {arg, arg} >> n[3:0];
    rol_res  = it.word_size ? rol_w[31:16] : {8'h00, rol_b[15:8]};
    ror_res  = it.word_size ? ror_w[15:0]  : {8'h00, ror_b[7:0]};
    cond_op  = {it.op[3:1], 1'b0};
    sidx     = 2'(it.op - BR_SENSE0);
    cond     = 1'b0;

    f        = flags;
    res      = arg;
    setzm    = 1'b0;
    wr_word  = 1'b0;
    wr_byte  = 8'h00;
    wr_o     = '0;
    res_o    = '0;
    res_o.halted = halted;

    unique case (it.cmd)
      CMD_ALU1: begin
        setzm = 1'b1;
        unique case (it.op)
          OP1_INC: begin
            res = inc_sum[15:0] & mask;
            f.v = res < arg;
          end
          OP1_DEC: begin
            res = dec_diff & mask;
            f.v = res > arg;
          end
          OP1_CLR: res = 16'h0000;
          OP1_NOT: res = ~arg & mask;
          OP1_SHL: begin
            res = shl_ext[15:0] & mask;
            f.c = it.word_size ? shl_ext[16] : shl_ext[8];
          end
          OP1_SHR: begin
            res = shr_ext[16:1];
            f.c = shr_ext[0];
          end
          OP1_ROL: begin
            res = rol_res;
            f.c = rol_res[0];
          end
          OP1_ROR: begin
            res = ror_res;
            f.c = |(ror_res & top);
          end
          default: setzm = 1'b0;
        endcase
        res_o.result = res;
      end
      CMD_ALU2: begin
        setzm = 1'b1;
        unique case (it.op)
          OP2_ADD: begin
            res = add_sum[15:0] & mask;
            f.c = it.word_size ? add_sum[16] : add_sum[8];
            f.v = |(~(arg ^ src) & (res ^ src) & top);
          end
          OP2_SUB: begin
            res = sub_diff & mask;
            f.c = arg < src;
            f.v = |((arg ^ src) & (res ^ arg) & top);
          end
          OP2_AND: res = arg & src;
          OP2_OR:  res = arg | src;
          OP2_XOR: res = arg ^ src;
          OP2_MOV: res = src;
          default: setzm = 1'b0;
        endcase
        res_o.result = res;
      end
      CMD_SYS: begin
        unique case (it.op)
          SYS_STOP:  res_o.halted = 1'b1;
          SYS_SET_M: f.m = 1'b1;
          SYS_CLR_M: f.m = 1'b0;
          SYS_SET_I: f.i = 1'b1;
          SYS_CLR_I: f.i = 1'b0;
          SYS_SET_C: f.c = 1'b1;
          SYS_CLR_C: f.c = 1'b0;
          SYS_RET: begin
            res_o.pc_load = 1'b1;
            res_o.new_pc  = rd_a;
          end
          default: ;
        endcase
      end
      CMD_BRANCH: begin
        if (it.op < BR_SENSE0) begin
          unique case (cond_op)
            BR_C:    cond = flags.c;
            BR_M:    cond = flags.m;
            BR_Z:    cond = flags.z;
            BR_LT:   cond = !flags.z && (flags.m != flags.v);
            BR_GT:   cond = !flags.z && (flags.m == flags.v);
            default: cond = 1'b0;
          endcase
          res_o.pc_load = it.op[0] ? !cond : cond;
        end else if (it.op < BR_NEVER) begin
          res_o.pc_load = !it.sense[sidx];
        end
        if (res_o.pc_load) begin
          res_o.new_pc = it.pc + {{8{it.offset[7]}}, it.offset};
        end
      end
      CMD_WRITE: begin
        wr_o.en = 1'b1;
        wr_byte = it.wbyte;
      end
      CMD_READ: res_o.result = {8'h00, a_byte};
      default: ;
    endcase

    if (setzm) begin
      f.z      = (res == 16'h0000);
      f.m      = |(res & top);
      wr_o.en  = 1'b1;
      wr_word  = it.word_size;
      wr_byte  = res[7:0];
    end

    wr_o.row = it.addr_a[7:1];
    if (wr_word) begin
      wr_o.we_hi = 1'b1;
      wr_o.we_lo = 1'b1;
      wr_o.hi    = res[15:8];
      wr_o.lo    = res[7:0];
    end else begin
      wr_o.we_hi = !it.addr_a[0];
      wr_o.we_lo = it.addr_a[0];
      wr_o.hi    = wr_byte;
      wr_o.lo    = wr_byte;
    end

    res_o.flags = f;
  end

endmodule

// ----- rtl/cpu_alu_flags_branch_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_flags_branch_unit
// Execution unit of a 16-bit CPU: banked 256-byte register file, status
// flags, halt bit, ALU, flag ops and branch evaluation.
//
//   channel | dir | tdata fields (low bit up)                      | tuser
//   in_     | in  | word_size op reg_a reg_b count_minus_one       | cmd
//           |     | offset current_pc int_level sense reg_address  |
//           |     | write_byte                                     |
//   out_    | out | result flag_c flag_v flag_z flag_m flag_i      | -
//           |     | pc_load new_pc cpu_halted                      |
//
// One item per cycle while the output does not stall; the acceptance edge reads
// the register file, and the execute stage executes, writes back and loads the
// output register as it advances. A write-back on the edge of the next item's
// read is bypassed to that item. Reset clears the register file through per-byte
// valid bits, clears the flags and sets the halt bit.
// A stalled output holds the execute stage, which holds the input.
// ----------------------------------------------------------------------------
module cpu_alu_flags_branch_unit
  import cafb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // word_size, op, reg_a, reg_b, count_minus_one, offset, current_pc,
  // int_level, sense, reg_address, write_byte, zero pad
  input  logic [71:0] in_tdata,
  // cmd
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result, flag_c, flag_v, flag_z, flag_m, flag_i, pc_load, new_pc,
  // cpu_halted, zero pad
  output logic [39:0] out_tdata
);

  logic        accept, ex_adv;
  logic [3:0]  bank;
  logic [7:0]  addr_a, addr_b;
  item_t       item_in;

  item_t       ex_item_r;
  logic        ex_valid_r, ex_valid_nxt;
  flags_t      flags_r;
  logic        halt_r;
  res_t        out_r;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] rd_a, rd_b;
  res_t        alu_res;
  wr_req_t     alu_wr, rf_wr;

  assign ex_adv    = ex_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !ex_valid_r || ex_adv;
  assign accept    = in_tvalid && in_tready;

  assign bank   = 4'(in_tdata[44:41] % LEVELS);
  assign addr_b = {bank, in_tdata[12:9]};

  always_comb begin
    unique case (in_tuser)
      CMD_READ, CMD_WRITE: addr_a = in_tdata[56:49];
      CMD_SYS:             addr_a = {bank, RET_REG};
      default:             addr_a = {bank, in_tdata[8:5]};
    endcase
    item_in.cmd       = in_tuser;
    item_in.word_size = in_tdata[0];
    item_in.op        = in_tdata[4:1];
    item_in.addr_a    = addr_a;
    item_in.addr_b    = addr_b;
    item_in.cnt       = in_tdata[16:13];
    item_in.offset    = in_tdata[24:17];
    item_in.pc        = in_tdata[40:25];
    item_in.sense     = in_tdata[48:45];
    item_in.wbyte     = in_tdata[64:57];
  end

  cafb_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_row_a  (addr_a[7:1]),
    .rd_row_b  (addr_b[7:1]),
    .wr        (rf_wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  cafb_alu u_alu (
    .it     (ex_item_r),
    .flags  (flags_r),
    .halted (halt_r),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .res_o  (alu_res),
    .wr_o   (alu_wr)
  );

  always_comb begin
    rf_wr    = alu_wr;
    rf_wr.en = alu_wr.en && ex_adv;
  end

  assign ex_valid_nxt  = accept || (ex_valid_r && !ex_adv);
  assign out_valid_nxt = ex_adv || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      halt_r      <= 1'b1;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ex_adv) begin
        flags_r <= alu_res.flags;
        halt_r  <= alu_res.halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ex_item_r <= item_in;
    if (ex_adv) out_r     <= alu_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.halted, out_r.new_pc, out_r.pc_load,
                       out_r.flags.i, out_r.flags.m, out_r.flags.z,
                       out_r.flags.v, out_r.flags.c, out_r.result};

endmodule
